/* rtl/core/lzsswd_pkg.sv */
// Shared widths and codes for the LZSS window decompressor.
package lzsswd_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned PosW        = $clog2(WindowDepth);
  localparam int unsigned DataW       = 8;
  localparam int unsigned LenW        = 4;
  localparam int unsigned FlagW       = 16;
  localparam int unsigned FlagCntW    = 5;
  localparam int unsigned OfsHiW      = PosW - DataW;

  // Role of the next compressed byte.
  typedef enum logic [1:0] {
    PhCtlLo  = 2'd0,
    PhCtlHi  = 2'd1,
    PhItem   = 2'd2,
    PhTokHi  = 2'd3
  } phase_e;

endpackage

/* rtl/core/lzss_window_decompressor_unit.sv */
// Top level of the LZSS decompressor: stream control, window memory and output register.
//
// LZSS decompressor with a 4096-byte history window. Compressed bytes enter one item per
// handshake on the slave side (tdata = compressed byte, tuser = restart flag); decompressed
// bytes leave on the master side with tlast set on the final byte produced by one input item.
// Each 16-bit control word (low byte first) carries 16 flags used LSB first: 0 = literal,
// 1 = two-byte token {offset[11:8], length-1[3:0], offset[7:0]}. Control bytes and a token's
// first byte produce nothing; a literal yields one byte; a token's second byte holds the input
// while the copy of length bytes (1..16) runs, as the window memory has a single registered
// read port; the copied bytes leave at one per cycle while the master side keeps up. Copies
// whose source is the byte just written (offset 1) are forwarded around the memory. The window
// has no clearing pass after reset; reading a never-written entry gives unspecified data. A
// restart keeps the window contents. Input ready also requires the output register to be free.
module lzss_window_decompressor_unit
  import lzsswd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic             s_axis_tuser_i,   // [0] new_stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic             m_axis_tlast_o    // last_of_run
);

  typedef enum logic {
    StIdle,
    StCopy
  } state_e;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [PosW-1:0]     wp_q, wp_d;          // window write position
  logic [FlagW-1:0]    flag_q, flag_d;      // remaining flags in the low bits
  logic [FlagCntW-1:0] fcnt_q, fcnt_d;      // flags left
  logic [DataW-1:0]    held_q, held_d;      // control low byte or token first byte
  logic [PosW-1:0]     ofs_q, ofs_d;        // copy offset
  logic [LenW-1:0]     rem_q, rem_d;        // copy reads still to issue
  logic                rd_pend_q, rd_pend_d;
  logic                fwd_q, fwd_d;
  logic [DataW-1:0]    fwd_data_q, fwd_data_d;
  logic                out_valid_q, out_valid_d;
  logic [DataW-1:0]    out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  // window memory
  logic [DataW-1:0]    win_mem [WindowDepth];
  logic                mem_we, mem_re;
  logic [PosW-1:0]     mem_waddr, mem_raddr;
  logic [DataW-1:0]    mem_wdata, rdata_q;

  logic                out_free, in_acc;
  logic [DataW-1:0]    copy_val;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign copy_val        = fwd_q ? fwd_data_q : rdata_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    phase_e              ph_e;
    logic [PosW-1:0]     wp_e;
    logic [FlagW-1:0]    flag_e;
    logic [FlagCntW-1:0] fcnt_e;
    logic [DataW-1:0]    held_e;
    logic [FlagCntW-1:0] fcnt_n;
    logic [PosW-1:0]     wp_n;

    state_d     = state_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    flag_d      = flag_q;
    fcnt_d      = fcnt_q;
    held_d      = held_q;
    ofs_d       = ofs_q;
    rem_d       = rem_q;
    rd_pend_d   = rd_pend_q;
    fwd_d       = fwd_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = wp_q;
    mem_wdata   = s_axis_tdata_i;
    mem_re      = 1'b0;
    mem_raddr   = wp_q;

    // restart wipes the stream state before the byte is used
    if (s_axis_tuser_i) begin
      ph_e   = PhCtlLo;
      wp_e   = '0;
      flag_e = '0;
      fcnt_e = '0;
      held_e = '0;
    end else begin
      ph_e   = phase_q;
      wp_e   = wp_q;
      flag_e = flag_q;
      fcnt_e = fcnt_q;
      held_e = held_q;
    end
    fcnt_n = (fcnt_e == '0) ? '0 : fcnt_e - FlagCntW'(1);
    wp_n   = wp_q + PosW'(1);

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          wp_d   = wp_e;
          flag_d = flag_e;
          fcnt_d = fcnt_e;
          held_d = held_e;
          unique case (ph_e)
            PhCtlLo: begin
              held_d  = s_axis_tdata_i;
              phase_d = PhCtlHi;
            end
            PhCtlHi: begin
              flag_d  = {s_axis_tdata_i, held_e};
              fcnt_d  = FlagCntW'(FlagW);
              phase_d = PhItem;
            end
            PhItem: begin
              if (flag_e[0]) begin
                held_d  = s_axis_tdata_i;
                phase_d = PhTokHi;
              end else begin
                // literal: store, emit, consume flag
                mem_we      = 1'b1;
                mem_waddr   = wp_e;
                mem_wdata   = s_axis_tdata_i;
                wp_d        = wp_e + PosW'(1);
                out_valid_d = 1'b1;
                out_data_d  = s_axis_tdata_i;
                out_last_d  = 1'b1;
                flag_d      = flag_e >> 1;
                fcnt_d      = fcnt_n;
                phase_d     = (fcnt_n == '0) ? PhCtlLo : PhItem;
              end
            end
            PhTokHi: begin
              ofs_d     = {s_axis_tdata_i[DataW-1 -: OfsHiW], held_e};
              rem_d     = s_axis_tdata_i[LenW-1:0];
              mem_re    = 1'b1;
              mem_raddr = wp_e - {s_axis_tdata_i[DataW-1 -: OfsHiW], held_e};
              fwd_d     = 1'b0;
              rd_pend_d = 1'b1;
              state_d   = StCopy;
            end
            default: ;
          endcase
        end
      end
      StCopy: begin
        if (rd_pend_q && out_free) begin
          mem_we      = 1'b1;
          mem_waddr   = wp_q;
          mem_wdata   = copy_val;
          wp_d        = wp_n;
          out_valid_d = 1'b1;
          out_data_d  = copy_val;
          out_last_d  = (rem_q == '0);
          if (rem_q != '0) begin
            rem_d      = rem_q - LenW'(1);
            mem_re     = 1'b1;
            mem_raddr  = wp_n - ofs_q;
            // source is the entry written this cycle: bypass the memory
            fwd_d      = ((wp_n - ofs_q) == wp_q);
            fwd_data_d = copy_val;
          end else begin
            rd_pend_d = 1'b0;
            state_d   = StIdle;
            flag_d    = flag_q >> 1;
            fcnt_d    = (fcnt_q == '0) ? '0 : fcnt_q - FlagCntW'(1);
            phase_d   = (fcnt_q <= FlagCntW'(1)) ? PhCtlLo : PhItem;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhCtlLo;
      wp_q        <= '0;
      flag_q      <= '0;
      fcnt_q      <= '0;
      held_q      <= '0;
      ofs_q       <= '0;
      rem_q       <= '0;
      rd_pend_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      flag_q      <= flag_d;
      fcnt_q      <= fcnt_d;
      held_q      <= held_d;
      ofs_q       <= ofs_d;
      rem_q       <= rem_d;
      rd_pend_q   <= rd_pend_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
    out_data_q <= out_data_d;
  end

  // window memory: one write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= win_mem[mem_raddr];
    end
  end

endmodule

/* rtl/core/lzsswd_checker.sv */
// Port-level checks for the LZSS window decompressor, bound to the top level.
module lzsswd_checker
  import lzsswd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [DataW-1:0] s_axis_tdata_i,   // [7:0] in_byte
  input logic             s_axis_tuser_i,   // [0] new_stream
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [DataW-1:0] m_axis_tdata_o,   // [7:0] out_byte
  input logic             m_axis_tlast_o    // last_of_run
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // input only taken when the output register can take a result
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready while output register blocked");

  // no new input while a copy run is unfinished
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready during copy run");

  // copy bytes follow without gaps while the output keeps up
  a_run_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside copy run");

  // input side is only observed
  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ s_axis_tuser_i ^ (^s_axis_tdata_i);

endmodule

bind lzss_window_decompressor_unit lzsswd_checker u_lzsswd_checker (.*);

/* verif/tb_lzss_window_decompressor_unit.sv */
// Self-checking testbench for the LZSS window decompressor: directed table, then random streams.
module tb_lzss_window_decompressor_unit
  import lzsswd_pkg::*;
;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } out_item_t;

  // Directed row: restart flag, compressed byte, and an optional typed literal result.
  typedef struct packed {
    logic             restart;
    logic [DataW-1:0] byte_in;
    logic             typed;
    logic [DataW-1:0] lit;
  } dir_row_t;

  localparam int NumDirRows = 19;
  localparam int NumRandom  = 351;
  localparam int HoldOffCyc = 300;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i;   // [7:0] in_byte
  logic             s_axis_tuser_i;   // [0] new_stream
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [DataW-1:0] m_axis_tdata_o;   // [7:0] out_byte
  logic             m_axis_tlast_o;   // last_of_run

  lzss_window_decompressor_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow copy of the decompressor state.
  logic [DataW-1:0] win_mem  [WindowDepth];
  bit               win_seen [WindowDepth];   // entry written since reset
  logic [PosW-1:0]  wr_pos;
  logic [15:0]      flag_sr;
  logic [4:0]       flags_left;
  phase_e           phase;
  logic [DataW-1:0] held_byte;
  logic [DataW-1:0] tok_hi_pending;           // second token byte chosen with the first

  out_item_t pending_out[$];
  int        mismatch_cnt;
  int        src_idle_pct;
  int        rcv_idle_pct;
  bit        hold_off_req;
  int        hold_left;

  // Literals typed where the row yields exactly that byte; tokens go through the predictor.
  dir_row_t dir_rows [NumDirRows] = '{
    // first stream, flags 0,0,1,0,1
    '{1'b1, 8'h14, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b1, 8'h00},   // literal, low extreme
    '{1'b0, 8'hff, 1'b1, 8'hff},   // literal, high extreme
    '{1'b0, 8'h02, 1'b0, 8'h00},   // token offset 2, length 16: overlapping copy
    '{1'b0, 8'h0f, 1'b0, 8'h00},
    '{1'b0, 8'h5a, 1'b1, 8'h5a},
    '{1'b0, 8'h01, 1'b0, 8'h00},   // token offset 1, length 1
    '{1'b0, 8'h00, 1'b0, 8'h00},
    // restart keeps the window, flags 0,1,1,1
    '{1'b1, 8'h0e, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00},
    '{1'b0, 8'h80, 1'b1, 8'h80},
    '{1'b0, 8'hff, 1'b0, 8'h00},   // token offset 4095, length 16
    '{1'b0, 8'hff, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00},   // token offset 0: re-emits the entry in place
    '{1'b0, 8'h00, 1'b0, 8'h00},
    '{1'b0, 8'h34, 1'b0, 8'h00},   // token cut short by a restart
    '{1'b1, 8'h00, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00}
  };

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void window_clear();
    foreach (win_seen[i]) begin
      win_seen[i] = 1'b0;
      win_mem[i]  = '0;
    end
    wr_pos     = '0;
    flag_sr    = '0;
    flags_left = '0;
    phase      = PhCtlLo;
    held_byte  = '0;
  endfunction

  function automatic void window_put(logic [DataW-1:0] v, bit last, bit push);
    win_mem[wr_pos]  = v;
    win_seen[wr_pos] = 1'b1;
    wr_pos           = wr_pos + 1'b1;
    if (push) pending_out.push_back('{data: v, last: last});
  endfunction

  function automatic void flag_consume();
    flag_sr = flag_sr >> 1;
    if (flags_left != 0) flags_left = flags_left - 1'b1;
    phase = (flags_left == 0) ? PhCtlLo : PhItem;
  endfunction

  // Expected output bytes for one compressed byte.
  function automatic void lzss_expand(bit restart, logic [DataW-1:0] b, bit push);
    logic [15:0]     tok;
    logic [PosW-1:0] ofs;
    int unsigned     len;
    if (restart) begin
      wr_pos     = '0;
      flag_sr    = '0;
      flags_left = '0;
      held_byte  = '0;
      phase      = PhCtlLo;
    end
    case (phase)
      PhCtlLo: begin
        held_byte = b;
        phase     = PhCtlHi;
      end
      PhCtlHi: begin
        flag_sr    = {b, held_byte};
        flags_left = 5'd16;
        phase      = PhItem;
      end
      PhItem: begin
        if (flag_sr[0]) begin
          held_byte = b;
          phase     = PhTokHi;
        end else begin
          window_put(b, 1'b1, push);
          flag_consume();
        end
      end
      default: begin
        tok = {b, held_byte};
        ofs = {tok[15:12], tok[7:0]};
        len = tok[11:8] + 1;
        // source follows the write pointer, so overlapping copies repeat bytes
        for (int unsigned i = 0; i < len; i++)
          window_put(win_mem[wr_pos - ofs], i == len - 1, push);
        flag_consume();
      end
    endcase
  endfunction

  // Every source byte of the copy must already hold written data.
  function automatic bit copy_ok(int unsigned ofs, int unsigned len);
    logic [PosW-1:0] src;
    for (int unsigned i = 0; i < len; i++) begin
      src = wr_pos + PosW'(i) - PosW'(ofs);
      if (!win_seen[src] && !(ofs != 0 && ofs <= i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [DataW-1:0] pick_token();
    int unsigned ofs;
    int unsigned len;
    int unsigned r;
    bit          ok;
    ok = 1'b0;
    for (int t = 0; t < 8 && !ok; t++) begin
      len = $urandom_range(16, 1);
      r   = $urandom_range(9);
      if (r == 0)     ofs = 0;
      else if (r < 3) ofs = $urandom_range(4095, 4000);
      else if (r < 7) ofs = $urandom_range(16, 1);
      else            ofs = $urandom_range(4095, 1);
      ok = copy_ok(ofs, len);
    end
    // offset 1 always reads the byte just written
    if (!ok) ofs = 1;
    tok_hi_pending = {4'(ofs >> 8), 4'(len - 1)};
    return ofs[7:0];
  endfunction

  // Next compressed byte: mostly well-formed streams, some stray restarts.
  task automatic pick_item(output bit restart, output logic [DataW-1:0] b);
    phase_e          ph;
    logic [PosW-1:0] pos;
    restart = ($urandom_range(99) < 2);
    if (phase == PhCtlLo && $urandom_range(99) < 15) restart = 1'b1;
    ph  = restart ? PhCtlLo : phase;
    pos = restart ? '0 : wr_pos;
    b   = DataW'($urandom);
    case (ph)
      // first flag may only be a token once the byte behind the pointer holds data
      PhCtlLo: if (!win_seen[pos - 1'b1]) b[0] = 1'b0;
      PhItem:  if (flag_sr[0]) b = pick_token();
      PhTokHi: b = tok_hi_pending;
      default: ;
    endcase
  endtask

  task automatic drive_item(bit restart, logic [DataW-1:0] b);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= restart;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    hold_left       = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCyc;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_out.size() == 0) begin
        $error("unexpected output byte 0x%02h last %0b", m_axis_tdata_o, m_axis_tlast_o);
        mismatch_cnt++;
      end else begin
        if (m_axis_tdata_o !== pending_out[0].data) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", pending_out[0].data, m_axis_tdata_o);
          mismatch_cnt++;
        end
        if (m_axis_tlast_o !== pending_out[0].last) begin
          $error("last_of_run: expected %0b, got %0b", pending_out[0].last, m_axis_tlast_o);
          mismatch_cnt++;
        end
        void'(pending_out.pop_front());
      end
    end
  end

  initial begin
    #3000000;
    $display("** lzss_window_decompressor_unit: FAILED **");
    $finish;
  end

  initial begin
    bit               restart;
    logic [DataW-1:0] b;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    hold_off_req    = 1'b0;
    mismatch_cnt    = 0;
    src_idle_pct    = 24;
    rcv_idle_pct    = 62;
    window_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      lzss_expand(dir_rows[i].restart, dir_rows[i].byte_in, !dir_rows[i].typed);
      if (dir_rows[i].typed) pending_out.push_back('{data: dir_rows[i].lit, last: 1'b1});
      drive_item(dir_rows[i].restart, dir_rows[i].byte_in);
    end

    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 3) begin
        src_idle_pct = 62;
        rcv_idle_pct = 24;
      end
      if (k == 2 * NumRandom / 3) begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // output stalls for a long stretch while input keeps coming
      if (k == 2 * NumRandom / 3 + 10) hold_off_req = 1'b1;
      pick_item(restart, b);
      lzss_expand(restart, b, 1'b1);
      drive_item(restart, b);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** lzss_window_decompressor_unit: PASSED **");
    end else begin
      $display("** lzss_window_decompressor_unit: FAILED **");
    end
    $finish;
  end

endmodule
